>>> rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, masked while reset is high
`define SFSP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs through reset
`define SFSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/sfsp_pkg.sv
`timescale 1ns / 1ps

package sfsp_pkg;

  // default width limit of sizes and counts
  localparam int SFSP_COUNT_BITS = 32;
  // width of each count field on the result word
  localparam int OUT_BITS = 32;
  // result word: size, count, status, zero fill to whole bytes
  localparam int M_TDATA_BITS = 72;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 4;

  // whitespace codes besides the plain space
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_VT  = 8'h0b;
  localparam logic [7:0] CH_FF  = 8'h0c;
  localparam logic [7:0] CH_CR  = 8'h0d;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_UNSUP = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_NATIVE_LONG = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NATIVE_SIZE = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ALIGN_FOUR  = 2'd2;

  typedef enum logic [3:0] {
    CC_ORDER = 4'd0,
    CC_DIGIT = 4'd1,
    CC_NUM   = 4'd2,
    CC_CHAR  = 4'd3,
    CC_STR   = 4'd4,
    CC_PAD   = 4'd5,
    CC_SPACE = 4'd6,
    CC_UNSUP = 4'd7,
    CC_BAD   = 4'd8
  } char_class_t;

  // numeric code size as a shift (bytes = 1 << shift)
  typedef struct packed {
    logic       valid;
    logic [1:0] shift;
  } num_size_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    case (c)
      "@", "=", "<", ">", "!": r = CC_ORDER;
      "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": r = CC_DIGIT;
      "b", "B", "h", "H", "i", "I", "l", "L", "q", "Q", "d", "f", "N": r = CC_NUM;
      "c", "?": r = CC_CHAR;
      "s", "p": r = CC_STR;
      "x": r = CC_PAD;
      " ", CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: r = CC_SPACE;
      "P": r = CC_UNSUP;
      default: r = CC_BAD;
    endcase
    return r;
  endfunction

  // size of a numeric code under the current byte order
  function automatic num_size_t num_size(input logic [7:0] c, input logic native,
                                         input logic long8, input logic size8);
    num_size_t r;
    r.valid = 1'b1;
    r.shift = 2'd0;
    case (c)
      "b", "B": r.shift = 2'd0;
      "h", "H": r.shift = 2'd1;
      "i", "I", "f": r.shift = 2'd2;
      "q", "Q", "d": r.shift = 2'd3;
      "l", "L": r.shift = (native && long8) ? 2'd3 : 2'd2;
      "N": begin
        r.valid = native;
        r.shift = size8 ? 2'd3 : 2'd2;
      end
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/struct_format_size_parser_core.sv
`timescale 1ns / 1ps
// Packed-structure format size parser.
// Input stream: one format character per word. s_tdata carries the character code,
// s_tuser says a character is present (clear it only to end an empty string), and
// s_tlast marks the final word of a format string.
// Output stream: one result word per string, sent for the word that carries s_tlast:
// total packed size, number of values and a status code (ok, bad character,
// unsupported P, count overflow). Errors latch and zero or saturate the counts.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 native long size, 1 native size_t size, 2 eight-byte items align to four);
// write only while no string is in flight.
// Throughput: one character per cycle, except that a last word waits in the input
// register while a result is held. Each word is held in the input register, then
// folded into the parse state; for a last word that edge also loads the result
// register and raises m_tvalid. The parse state loop (shift, add, round-up to the
// alignment, overflow compare) sets the clock period.
// When the receiver stalls, the result is held and words that are not last keep
// flowing through the input register; the next last word waits there and s_tready
// drops until the held result leaves.
// Synchronous reset empties both registers, restores native byte order and
// the register defaults (8, 8, 0).

module struct_format_size_parser_core #(
  parameter int COUNT_BITS = sfsp_pkg::SFSP_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [7:0] fmt_char
  input  logic                              s_tuser,   // [0] char_present
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [31:0] total_size, [63:32] item_count, [65:64] status, rest zero
  output logic [sfsp_pkg::M_TDATA_BITS-1:0] m_tdata,
  input  logic                              cfg_we,
  input  logic [sfsp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [sfsp_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import sfsp_pkg::*;

  localparam int CW = (COUNT_BITS >= OUT_BITS) ? OUT_BITS : COUNT_BITS;
  localparam int WW = CW + 4;
  localparam int FILL_BITS = M_TDATA_BITS - 2 * OUT_BITS - 2;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_present;
  logic       in_last;

  // configuration
  logic native_long8;
  logic native_size8;
  logic align_four;

  // parse state
  logic          native_order, native_order_next;
  logic          at_first;
  logic [CW-1:0] repeat_value, repeat_value_next;
  logic          repeat_given, repeat_given_next;
  logic [CW-1:0] run_size, run_size_next;
  logic [CW-1:0] run_items, run_items_next;
  status_t       first_error, first_error_next;

  // result register
  logic [CW-1:0] out_size, out_size_next;
  logic [CW-1:0] out_items, out_items_next;
  status_t       out_status;

  logic          out_free;
  logic          proc;
  logic          work;
  char_class_t   cls;
  num_size_t     nsz;
  logic [CW-1:0] cnt;
  logic [1:0]    ash;
  logic [WW-1:0] prod;
  logic [WW-1:0] mask;
  logic [WW-1:0] size_add;
  logic [CW:0]   item_add;
  logic [WW-1:0] size_sum;
  logic [WW-1:0] size_rnd;
  logic [CW:0]   items_sum;
  logic [WW-1:0] digit_val;
  logic          sum_ovf;

  // handshake: the input register drains unless a last word meets a held result
  assign out_free = !m_tvalid || m_tready;
  assign proc     = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || proc;
  assign work     = proc && in_present && (first_error == ST_OK);

  // decode and count arithmetic
  always_comb begin
    cls = classify(in_char);
    nsz = num_size(in_char, native_order, native_long8, native_size8);
    cnt = repeat_given ? repeat_value : CW'(1);
    prod = WW'(cnt) << nsz.shift;
    if (cls != CC_NUM || !native_order) begin
      ash = 2'd0;
    end else if (nsz.shift == 2'd3 && align_four) begin
      ash = 2'd2;
    end else begin
      ash = nsz.shift;
    end
    mask = (WW'(1) << ash) - WW'(1);
    case (cls)
      CC_NUM: begin
        size_add = prod;
        item_add = (CW+1)'(cnt);
      end
      CC_CHAR: begin
        size_add = WW'(cnt);
        item_add = (CW+1)'(cnt);
      end
      CC_STR: begin
        size_add = WW'(cnt);
        item_add = (CW+1)'(1);
      end
      CC_PAD: begin
        size_add = WW'(cnt);
        item_add = '0;
      end
      default: begin
        size_add = '0;
        item_add = '0;
      end
    endcase
    size_sum  = WW'(run_size) + size_add;
    size_rnd  = (size_sum + mask) & ~mask;
    items_sum = (CW+1)'(run_items) + item_add;
    sum_ovf   = (|size_rnd[WW-1:CW]) || items_sum[CW];
    digit_val = (WW'(repeat_value) << 3) + (WW'(repeat_value) << 1) + WW'(in_char[3:0]);
  end

  // next parse state for the word in the input register
  always_comb begin
    native_order_next = native_order;
    repeat_value_next = repeat_value;
    repeat_given_next = repeat_given;
    run_size_next     = run_size;
    run_items_next    = run_items;
    first_error_next  = first_error;
    if (work) begin
      case (cls)
        CC_ORDER: begin
          if (!at_first) begin
            first_error_next = ST_BAD;
          end else begin
            native_order_next = (in_char == "@");
          end
        end
        CC_DIGIT: begin
          if (|digit_val[WW-1:CW]) begin
            first_error_next = ST_OVF;
          end else begin
            repeat_value_next = digit_val[CW-1:0];
            repeat_given_next = 1'b1;
          end
        end
        CC_NUM, CC_CHAR, CC_STR, CC_PAD: begin
          if (cls == CC_NUM && !nsz.valid) begin
            first_error_next = ST_BAD;
          end else begin
            repeat_value_next = '0;
            repeat_given_next = 1'b0;
            run_size_next     = size_rnd[CW-1:0];
            run_items_next    = items_sum[CW-1:0];
            if (sum_ovf) begin
              first_error_next = ST_OVF;
            end
          end
        end
        CC_SPACE: begin
        end
        CC_UNSUP: first_error_next = ST_UNSUP;
        default: first_error_next = ST_BAD;
      endcase
    end
  end

  // result fields by status
  always_comb begin
    case (first_error_next)
      ST_OK: begin
        out_size_next  = run_size_next;
        out_items_next = run_items_next;
      end
      ST_OVF: begin
        out_size_next  = '1;
        out_items_next = '1;
      end
      default: begin
        out_size_next  = '0;
        out_items_next = '0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_char    <= s_tdata;
      in_present <= s_tuser;
      in_last    <= s_tlast;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      native_long8 <= 1'b1;
      native_size8 <= 1'b1;
      align_four   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NATIVE_LONG: native_long8 <= cfg_wdata[3];
        REG_NATIVE_SIZE: native_size8 <= cfg_wdata[3];
        REG_ALIGN_FOUR:  align_four   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // parse state, cleared after each string
  always_ff @(posedge clk) begin
    if (rst || (proc && in_last)) begin
      native_order <= 1'b1;
      at_first     <= 1'b1;
      repeat_value <= '0;
      repeat_given <= 1'b0;
      run_size     <= '0;
      run_items    <= '0;
      first_error  <= ST_OK;
    end else if (proc) begin
      native_order <= native_order_next;
      at_first     <= at_first && !in_present;
      repeat_value <= repeat_value_next;
      repeat_given <= repeat_given_next;
      run_size     <= run_size_next;
      run_items    <= run_items_next;
      first_error  <= first_error_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (proc && in_last) begin
      out_size   <= out_size_next;
      out_items  <= out_items_next;
      out_status <= first_error_next;
    end
  end

  assign m_tdata = {{FILL_BITS{1'b0}}, out_status, OUT_BITS'(out_items), OUT_BITS'(out_size)};

endmodule

>>> rtl/core/sfsp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfsp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               s_tlast,
  input logic                               m_tvalid,
  input logic                               m_tready,
  // [31:0] total_size, [63:32] item_count, [65:64] status, rest zero
  input logic [sfsp_pkg::M_TDATA_BITS-1:0]  m_tdata
);
  import sfsp_pkg::*;

  logic       last_word_in;
  logic       stalled;
  logic       char_err;
  logic       counts_zero;
  logic [1:0] res_status;

  assign last_word_in = s_tvalid && s_tready && s_tlast;
  assign res_status   = m_tdata[2*OUT_BITS+1:2*OUT_BITS];
  assign stalled      = m_tvalid && !m_tready;
  assign char_err     = m_tvalid && (res_status == ST_BAD || res_status == ST_UNSUP);
  assign counts_zero  = (m_tdata[2*OUT_BITS-1:0] == '0);

  // reset empties the result register
  `SFSP_ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !m_tvalid, "result valid after reset")

  // a held result keeps its word
  `SFSP_ASSERT(a_hold, clk, rst, stalled |=> (m_tvalid && $stable(m_tdata)), "held word changed")

  // a fresh result follows an accepted last word
  `SFSP_ASSERT(a_result_src, clk, rst, $rose(m_tvalid) |-> $past(last_word_in, 2), "stray result")

  // input backs up only behind a stalled result
  `SFSP_ASSERT(a_ready_cause, clk, rst, !s_tready |-> stalled, "input stalled without cause")

  // character errors report zero counts
  `SFSP_ASSERT(a_err_zero, clk, rst, char_err |-> counts_zero, "nonzero counts on error")

endmodule

bind struct_format_size_parser_core sfsp_checker u_sfsp_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tlast   (s_tlast),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
